// ===== rtl/feedback_delay_line_assert.svh =====
// Assertion helpers shared by the RTL. All checks sample on clk and are
// muted while rst is high.
`ifndef FEEDBACK_DELAY_LINE_ASSERT_SVH
`define FEEDBACK_DELAY_LINE_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define FDL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define FDL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent at the following edge.
`define FDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fdl_pkg.sv =====
package fdl_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_DELAY   = 65536;
  localparam int ADDR_BITS   = 16;
  localparam int LEN_BITS    = 17;
  localparam int GAIN_BITS   = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 17;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [LEN_BITS-1:0]           len_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;
  typedef logic [CFG_INDEX_BITS-1:0]     cfg_index_t;

  // Register indexes on the configuration port
  localparam cfg_index_t REG_DELAY_LENGTH  = 2'd0;
  localparam cfg_index_t REG_FEEDBACK_GAIN = 2'd1;
  localparam cfg_index_t REG_EFFECT_ENABLE = 2'd2;

  localparam len_t  DELAY_RESET = 17'd22050;
  localparam len_t  DELAY_MAX   = 17'd65536;
  localparam gain_t GAIN_RESET  = 16'd16384;
  localparam gain_t GAIN_ONE    = 16'd32768;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  // Sample stage between the memory read and the write-back
  typedef struct packed {
    logic    valid;
    logic    en;
    logic    known;
    logic    fwd;
    addr_t   addr;
    sample_t sample;
  } stage_t;

endpackage

// ===== rtl/fdl_ram.sv =====
module fdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address collision; rdata holds
  // while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/feedback_delay_line.sv =====
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+--------------------------------
// s_*      | in  | s_tvalid / s_tready       | s_tdata[15:0] in_sample
// m_*      | out | m_tvalid / m_tready       | m_tdata[15:0] out_sample
// cfg_*    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data (registers)
//
// One beat per cycle sustained while m_tready is high; each beat passes the
// sample stage, then the output register. The echo memory port (one read,
// one write per cycle) sets that rate. Reset is synchronous; the memory needs
// no clearing pass after reset. A stalled output holds the sample stage,
// which then holds the input side. cfg_ready is always high.
`include "feedback_delay_line_assert.svh"

module feedback_delay_line
  import fdl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // Input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [SAMPLE_BITS-1:0]    s_tdata,    // [15:0] in_sample
  // Output stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [SAMPLE_BITS-1:0]    m_tdata,    // [15:0] out_sample
  // Configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers
  len_t  delay_length;
  gain_t feedback_gain;
  logic  effect_enable;

  // Ring pointer and fill count. Writes only ever land at the pointer, and
  // the pointer only steps by one or returns to zero, so the written entries
  // always form a prefix [0, fill). Anything at or above fill reads as zero,
  // which stands in for clearing the memory at reset.
  addr_t ptr;
  len_t  fill;

  stage_t  s1;
  sample_t fwd_data;
  sample_t rdata;

  len_t    len_eff;
  gain_t   gain_eff;
  addr_t   ptr_cur;
  len_t    ptr_inc;
  addr_t   ptr_next;
  logic    accept;
  logic    rd_en;
  logic    s1_adv;
  logic    ram_we;
  sample_t entry;

  logic signed [32:0] prod;
  logic signed [32:0] prod_rnd;
  logic signed [17:0] rnd;
  logic signed [18:0] total;
  sample_t            wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= DELAY_RESET;
      feedback_gain <= GAIN_RESET;
      effect_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DELAY_LENGTH:  delay_length  <= cfg_data;
        REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[GAIN_BITS-1:0];
        REG_EFFECT_ENABLE: effect_enable <= cfg_data[0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Clamp length to 1..MAX_DELAY and gain to 1.0
  always_comb begin
    if (delay_length == '0) begin
      len_eff = len_t'(1);
    end else if (delay_length > DELAY_MAX) begin
      len_eff = DELAY_MAX;
    end else begin
      len_eff = delay_length;
    end
    gain_eff = (feedback_gain > GAIN_ONE) ? GAIN_ONE : feedback_gain;
  end

  // A pointer left past the end by a shrink restarts at zero
  always_comb begin
    ptr_cur  = ({1'b0, ptr} >= len_eff) ? '0 : ptr;
    ptr_inc  = {1'b0, ptr_cur} + len_t'(1);
    ptr_next = (ptr_inc >= len_eff) ? '0 : ptr_inc[ADDR_BITS-1:0];
  end

  assign s1_adv   = s1.valid && (!m_tvalid || m_tready);
  assign s_tready = !s1.valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign rd_en    = accept && effect_enable;
  assign ram_we   = s1_adv && s1.en;

  fdl_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_DELAY)
  ) u_echo_mem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1.addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(ptr_cur),
    .rdata(rdata)
  );

  // Sample stage: holds the beat while its memory read completes.
  // When the beat ahead writes the same entry in the cycle this read is
  // issued (ring length one), the memory returns the old value, so take the
  // written value from the bypass register instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s1.fwd   <= 1'b0;
      ptr      <= '0;
      fill     <= '0;
    end else begin
      if (accept) begin
        s1.valid  <= 1'b1;
        s1.fwd    <= rd_en && ram_we && (s1.addr == ptr_cur);
        s1.en     <= effect_enable;
        s1.known  <= ({1'b0, ptr_cur} < fill);
        s1.addr   <= ptr_cur;
        s1.sample <= sample_t'(s_tdata);
      end else if (s1_adv) begin
        s1.valid <= 1'b0;
      end
      if (rd_en) begin
        ptr <= ptr_next;
      end
      // Grow the written prefix when the write lands just past it
      if (ram_we && ({1'b0, s1.addr} == fill)) begin
        fill <= fill + len_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= wr_data;
    end
  end

  // Feedback: entry * gain in Q1.15, round half up, add input, saturate
  always_comb begin
    if (s1.fwd) begin
      entry = fwd_data;
    end else if (s1.known) begin
      entry = rdata;
    end else begin
      entry = '0;
    end
    prod     = $signed({1'b0, gain_eff}) * entry;
    prod_rnd = prod + 33'sd16384;
    rnd      = prod_rnd[32:15];
    total    = {{3{s1.sample[SAMPLE_BITS-1]}}, s1.sample} + {rnd[17], rnd};
    if (total > 19'sd32767) begin
      wr_data = SAMPLE_MAX;
    end else if (total < -19'sd32768) begin
      wr_data = SAMPLE_MIN;
    end else begin
      wr_data = total[SAMPLE_BITS-1:0];
    end
  end

  // Output register: wet sample when enabled, dry input otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= s1.en ? entry : s1.sample;
    end
  end

  `FDL_ASSERT_ALWAYS(a_fill_bound, fill <= DELAY_MAX, "fill count beyond memory depth")
  `FDL_ASSERT_NEXT(a_ptr_range, rd_en, {1'b0, ptr} < len_eff, "ring pointer past length")
  `FDL_ASSERT_NEXT(a_fill_mono, 1'b1, fill >= $past(fill), "fill count went backward")
  `FDL_ASSERT_NEXT(a_stage_hold, s1.valid && !s1_adv, s1.valid && $stable(s1.addr), "stalled stage lost")
  `FDL_ASSERT_IMPL(a_out_source, $rose(m_tvalid), $past(s1.valid), "output beat without a source")

endmodule
